// File: rtl/sik_pkg.sv
package sik_pkg;

    localparam int AXIS_BITS     = 16;
    localparam int CORDIC_STAGES = 16;

    // pair operands h +- s*kl, v +- s*kw
    localparam int AB_W       = AXIS_BITS + 2;
    // sum of two squares and its square root
    localparam int SQ_W       = 2 * AB_W;
    localparam int SQRT_STEPS = SQ_W / 2;
    localparam int ROOT_W     = SQ_W / 2;
    // cordic datapath, operands scaled by 2^16 plus growth headroom
    localparam int CW         = AB_W + 16 + 4;
    localparam int CHAIN      = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;
    localparam int STAGE_W    = 5;

    localparam int K_W        = 16;
    localparam int GAIN_W     = 16;
    localparam int PROD_W     = ROOT_W + GAIN_W;
    localparam int ANG_W      = 16;
    localparam int SPD_W      = 19;

    localparam logic [SPD_W-1:0] SPEED_MAX = 19'd262143;

    localparam logic [1:0] MODE_DRIVE = 2'd0;
    localparam logic [1:0] MODE_WAIT  = 2'd1;
    localparam logic [1:0] MODE_IDLE  = 2'd2;

    localparam logic [1:0] REG_LENGTH = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_GAIN   = 2'd2;
    localparam logic [1:0] REG_WAIT   = 2'd3;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [31:0]          z;
        logic                 zero;
        logic [SQ_W-1:0]      rem;
        logic [SQ_W-1:0]      root;
    } wheel_t;

    typedef struct packed {
        logic           busy;
        logic [K_W-1:0] kl;
        logic [K_W-1:0] kw;
    } geom_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [STAGE_W-1:0] i);
        logic [31:0] r;
        unique case (i)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41721;
            5'd15: r = 32'd20860;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2607;
            5'd19: r = 32'd1303;
            5'd20: r = 32'd651;
            5'd21: r = 32'd325;
            5'd22: r = 32'd162;
            5'd23: r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/swerve_inverse_kinematics.sv
// Four-wheel swerve inverse kinematics. A request of three Q1.15 axes and the
// swivel flags gives four swivel angles, four saturated wheel speeds and a
// mode. One request is taken every clock cycle while in_stall is low; each
// passes through 4 + (cordic/root cell chain, 18 cells) + 2 = 24 register
// stages before its result is shown. A write of base_length or base_width
// starts a geometry unit that runs a multiply, a sum, 31 divide steps and 16
// root steps, and in_stall is held high while it runs; the same pass runs
// once after reset.
module swerve_inverse_kinematics (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [15:0]                 axis_vertical,
    input  logic signed [15:0]                 axis_horizontal,
    input  logic signed [15:0]                 axis_spin,
    input  logic [3:0]                         swivels_ready,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [sik_pkg::ANG_W-1:0]   front_left_angle,
    output logic signed [sik_pkg::ANG_W-1:0]   front_right_angle,
    output logic signed [sik_pkg::ANG_W-1:0]   back_left_angle,
    output logic signed [sik_pkg::ANG_W-1:0]   back_right_angle,
    output logic signed [sik_pkg::SPD_W-1:0]   front_left_speed,
    output logic signed [sik_pkg::SPD_W-1:0]   front_right_speed,
    output logic signed [sik_pkg::SPD_W-1:0]   back_left_speed,
    output logic signed [sik_pkg::SPD_W-1:0]   back_right_speed,
    output logic [1:0]                         drive_mode,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [1:0]                         cfg_index,
    input  logic [15:0]                        cfg_data
);
    import sik_pkg::*;

    logic [15:0] len_reg, wid_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic wait_reg;
    logic cfg_wr, geom_start, adv, acc_in;
    geom_t geom;

    // front stages
    logic                     vld1_reg, vld2_reg, vld3_reg, vld4_reg, vld5_reg;
    logic [1:0]               mode1_reg, mode2_reg, mode3_reg, mode4_reg, mode5_reg;
    logic [1:0]               mode_in;
    logic signed [15:0]       v1_reg, h1_reg;
    logic signed [32:0]       pl1_reg, pw1_reg, pl_next, pw_next;
    logic signed [AB_W-1:0]   sl, sw;
    logic signed [AB_W-1:0]   a2_reg, b2_reg, c2_reg, d2_reg;
    logic [SQ_W-1:0]          sqa3_reg, sqb3_reg, sqc3_reg, sqd3_reg;
    logic signed [2*AB_W-1:0] pa, pb, pc, pd;
    wheel_t                   w3_reg [4];
    wheel_t                   w4_reg [4];
    wheel_t                   w4_next [4];
    logic [SQ_W-1:0]          sum4 [4];

    // cell chain
    wheel_t                   cw [4][CHAIN];
    logic                     vldc_reg [CHAIN];
    logic [1:0]               modec_reg [CHAIN];

    // back stages
    logic [ANG_W-1:0]         ang5_reg [4];
    logic [PROD_W-1:0]        prod5_reg [4];
    logic [ANG_W-1:0]         rnd [4];
    logic [PROD_W-1:0]        shf [4];
    logic [SPD_W-1:0]         mag [4];
    logic                     out_valid_reg;
    logic [ANG_W-1:0]         ang_reg [4];
    logic [SPD_W-1:0]         spd_reg [4];
    logic [1:0]               mode_reg;

    function automatic wheel_t pair_init(input logic signed [AB_W-1:0] p,
                                         input logic signed [AB_W-1:0] q);
        wheel_t w;
        w.zero = (p == '0) && (q == '0);
        w.rem  = '0;
        w.root = '0;
        // left half plane starts at half a turn
        if (q[AB_W-1])
        begin
            w.x = -(CW'(q) <<< 16);
            w.y = -(CW'(p) <<< 16);
            w.z = 32'h8000_0000;
        end
        else
        begin
            w.x = CW'(q) <<< 16;
            w.y = CW'(p) <<< 16;
            w.z = 32'h0;
        end
        return w;
    endfunction

    // configuration
    assign cfg_ready  = 1'b1;
    assign cfg_wr     = cfg_valid && cfg_ready;
    assign geom_start = cfg_wr && (cfg_index == REG_LENGTH || cfg_index == REG_WIDTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= 16'd256;
            wid_reg  <= 16'd256;
            gain_reg <= 16'd256;
            wait_reg <= 1'b1;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                REG_LENGTH: len_reg  <= cfg_data;
                REG_WIDTH:  wid_reg  <= cfg_data;
                REG_GAIN:   gain_reg <= cfg_data;
                REG_WAIT:   wait_reg <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    sik_geom u_geom (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (geom_start),
        .base_length (len_reg),
        .base_width  (wid_reg),
        .stat        (geom)
    );

    // whole pipe moves when the output register is free or being taken
    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = geom.busy || !adv;
    assign acc_in   = in_valid && !in_stall;

    always_comb
    begin
        if (axis_vertical == '0 && axis_horizontal == '0 && axis_spin == '0)
            mode_in = MODE_IDLE;
        else if (wait_reg && swivels_ready != 4'hF)
            mode_in = MODE_WAIT;
        else
            mode_in = MODE_DRIVE;
        pl_next = axis_spin * $signed({1'b0, geom.kl});
        pw_next = axis_spin * $signed({1'b0, geom.kw});
        sl = AB_W'(pl1_reg >>> 15);
        sw = AB_W'(pw1_reg >>> 15);
        pa = a2_reg * a2_reg;
        pb = b2_reg * b2_reg;
        pc = c2_reg * c2_reg;
        pd = d2_reg * d2_reg;
        sum4[0] = sqb3_reg + sqc3_reg;
        sum4[1] = sqb3_reg + sqd3_reg;
        sum4[2] = sqa3_reg + sqc3_reg;
        sum4[3] = sqa3_reg + sqd3_reg;
        for (int i = 0; i < 4; i++)
        begin
            w4_next[i]     = w3_reg[i];
            w4_next[i].rem = sum4[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < CHAIN; k++)
            begin
                vldc_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld1_reg <= acc_in;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
            vldc_reg[0] <= vld4_reg;
            for (int k = 1; k < CHAIN; k++)
            begin
                vldc_reg[k] <= vldc_reg[k-1];
            end
            vld5_reg <= vldc_reg[CHAIN-1];
            out_valid_reg <= vld5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mode1_reg <= mode_in;
            v1_reg    <= axis_vertical;
            h1_reg    <= axis_horizontal;
            pl1_reg   <= pl_next;
            pw1_reg   <= pw_next;

            mode2_reg <= mode1_reg;
            a2_reg    <= AB_W'(h1_reg) - sl;
            b2_reg    <= AB_W'(h1_reg) + sl;
            c2_reg    <= AB_W'(v1_reg) - sw;
            d2_reg    <= AB_W'(v1_reg) + sw;

            mode3_reg <= mode2_reg;
            sqa3_reg  <= $unsigned(pa);
            sqb3_reg  <= $unsigned(pb);
            sqc3_reg  <= $unsigned(pc);
            sqd3_reg  <= $unsigned(pd);
            w3_reg[0] <= pair_init(b2_reg, c2_reg);
            w3_reg[1] <= pair_init(b2_reg, d2_reg);
            w3_reg[2] <= pair_init(a2_reg, c2_reg);
            w3_reg[3] <= pair_init(a2_reg, d2_reg);

            mode4_reg <= mode3_reg;
            for (int i = 0; i < 4; i++)
            begin
                w4_reg[i] <= w4_next[i];
            end

            modec_reg[0] <= mode4_reg;
            for (int k = 1; k < CHAIN; k++)
            begin
                modec_reg[k] <= modec_reg[k-1];
            end
        end
    end

    for (genvar i = 0; i < 4; i++)
    begin : g_wheel
        for (genvar k = 0; k < CHAIN; k++)
        begin : g_cell
            sik_cell u_cell (
                .clk   (clk),
                .en    (adv),
                .stage (STAGE_W'(k)),
                .d     ((k == 0) ? w4_reg[i] : cw[i][(k == 0) ? 0 : k-1]),
                .q     (cw[i][k])
            );
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            rnd[i] = 16'((cw[i][CHAIN-1].z + 32'h0000_8000) >> 16);
            shf[i] = prod5_reg[i] >> (AXIS_BITS - 1);
            mag[i] = (shf[i] > PROD_W'(SPEED_MAX)) ? SPEED_MAX : shf[i][SPD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mode5_reg <= modec_reg[CHAIN-1];
            for (int i = 0; i < 4; i++)
            begin
                ang5_reg[i]  <= cw[i][CHAIN-1].zero ? '0 : ANG_W'(0) - rnd[i];
                prod5_reg[i] <= cw[i][CHAIN-1].root[ROOT_W-1:0] * gain_reg;
            end

            mode_reg <= mode5_reg;
            for (int i = 0; i < 4; i++)
            begin
                ang_reg[i] <= (mode5_reg == MODE_IDLE) ? '0 : ang5_reg[i];
                if (mode5_reg != MODE_DRIVE)
                    spd_reg[i] <= '0;
                else if (i == 1 || i == 3)
                    spd_reg[i] <= SPD_W'(0) - mag[i];
                else
                    spd_reg[i] <= mag[i];
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign front_left_angle  = ang_reg[0];
    assign front_right_angle = ang_reg[1];
    assign back_left_angle   = ang_reg[2];
    assign back_right_angle  = ang_reg[3];
    assign front_left_speed  = spd_reg[0];
    assign front_right_speed = spd_reg[1];
    assign back_left_speed   = spd_reg[2];
    assign back_right_speed  = spd_reg[3];
    assign drive_mode        = mode_reg;

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && drive_mode == MODE_IDLE |->
            front_left_angle == '0 && back_right_angle == '0 &&
            front_left_speed == '0 && back_right_speed == '0)
        else $error("idle result not all zero");

    a_wait_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && drive_mode == MODE_WAIT |->
            front_left_speed == '0 && front_right_speed == '0 &&
            back_left_speed == '0 && back_right_speed == '0)
        else $error("wheel power while waiting for swivels");

    a_speed_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && drive_mode == MODE_DRIVE |->
            !front_left_speed[SPD_W-1] && !back_left_speed[SPD_W-1] &&
            (front_right_speed[SPD_W-1] || front_right_speed == '0))
        else $error("wheel speed sign wrong");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $past(geom_start) |-> !acc_in)
        else $error("request taken while geometry recomputes");

endmodule

// File: rtl/sik_geom.sv
module sik_geom (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [15:0]           base_length,
    input  logic [15:0]           base_width,
    output sik_pkg::geom_t        stat
);
    import sik_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_SQRT = 3'd4;

    localparam int DIV_STEPS = 31;
    localparam int KSQ_STEPS = 16;

    logic [2:0]  state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] l2_reg, w2_reg;
    logic [32:0] den_reg;
    logic [32:0] reml_reg, reml_next, remw_reg, remw_next;
    logic [30:0] ql_reg, ql_next, qw_reg, qw_next;
    logic [31:0] rootl_reg, rootl_next, rootw_reg, rootw_next;
    logic [K_W-1:0] kl_reg, kw_reg;
    logic [33:0] trl, trw;
    logic [31:0] sbit, stl, stw;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        reml_next  = reml_reg;
        remw_next  = remw_reg;
        ql_next    = ql_reg;
        qw_next    = qw_reg;
        rootl_next = rootl_reg;
        rootw_next = rootw_reg;
        // restoring division, one quotient bit a cycle
        trl = {reml_reg, (cnt_reg == 5'd0) ? l2_reg[0] : 1'b0};
        trw = {remw_reg, (cnt_reg == 5'd0) ? w2_reg[0] : 1'b0};
        // square root, one result bit a cycle
        sbit = 32'h4000_0000 >> {cnt_reg, 1'b0};
        stl  = rootl_reg + sbit;
        stw  = rootw_reg + sbit;
        unique case (state_reg)
            ST_MUL:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                reml_next  = {2'b0, l2_reg[31:1]};
                remw_next  = {2'b0, w2_reg[31:1]};
                cnt_next   = 5'd0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (trl >= {1'b0, den_reg})
                begin
                    reml_next = 33'(trl - {1'b0, den_reg});
                    ql_next   = {ql_reg[29:0], 1'b1};
                end
                else
                begin
                    reml_next = trl[32:0];
                    ql_next   = {ql_reg[29:0], 1'b0};
                end
                if (trw >= {1'b0, den_reg})
                begin
                    remw_next = 33'(trw - {1'b0, den_reg});
                    qw_next   = {qw_reg[29:0], 1'b1};
                end
                else
                begin
                    remw_next = trw[32:0];
                    qw_next   = {qw_reg[29:0], 1'b0};
                end
                if (cnt_reg == 5'(DIV_STEPS - 1))
                begin
                    cnt_next   = 5'd0;
                    rootl_next = 32'd0;
                    rootw_next = 32'd0;
                    state_next = ST_SQRT;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_SQRT:
            begin
                if ({1'b0, ql_reg} >= stl)
                begin
                    ql_next    = 31'({1'b0, ql_reg} - stl);
                    rootl_next = (rootl_reg >> 1) + sbit;
                end
                else
                begin
                    rootl_next = rootl_reg >> 1;
                end
                if ({1'b0, qw_reg} >= stw)
                begin
                    qw_next    = 31'({1'b0, qw_reg} - stw);
                    rootw_next = (rootw_reg >> 1) + sbit;
                end
                else
                begin
                    rootw_next = rootw_reg >> 1;
                end
                if (cnt_reg == 5'(KSQ_STEPS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (start)
        begin
            state_next = ST_MUL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_MUL;
            cnt_reg   <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        l2_reg    <= base_length * base_length;
        w2_reg    <= base_width * base_width;
        den_reg   <= {1'b0, l2_reg} + {1'b0, w2_reg};
        reml_reg  <= reml_next;
        remw_reg  <= remw_next;
        ql_reg    <= ql_next;
        qw_reg    <= qw_next;
        rootl_reg <= rootl_next;
        rootw_reg <= rootw_next;
        if (state_reg == ST_SQRT && state_next == ST_IDLE)
        begin
            // zero geometry gives zero factors
            kl_reg <= (den_reg == 33'd0) ? '0 : rootl_next[K_W-1:0];
            kw_reg <= (den_reg == 33'd0) ? '0 : rootw_next[K_W-1:0];
        end
    end

    assign stat.busy = (state_reg != ST_IDLE);
    assign stat.kl   = kl_reg;
    assign stat.kw   = kw_reg;

    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        !stat.busy |-> (kl_reg <= 16'd32768 && kw_reg <= 16'd32768))
        else $error("geometry factor out of range");

    a_cnt_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> cnt_reg < 5'(DIV_STEPS))
        else $error("divide step count overrun");

    a_cnt_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SQRT |-> cnt_reg < 5'(KSQ_STEPS))
        else $error("root step count overrun");

endmodule

// File: rtl/sik_cell.sv
module sik_cell (
    input  logic                         clk,
    input  logic                         en,
    input  logic [sik_pkg::STAGE_W-1:0]  stage,
    input  sik_pkg::wheel_t              d,
    output sik_pkg::wheel_t              q
);
    import sik_pkg::*;

    wheel_t               q_reg, q_next;
    logic signed [CW-1:0] tx, ty;
    logic [SQ_W-1:0]      bit_w, trial;

    always_comb
    begin
        q_next = d;
        tx     = d.x >>> stage;
        ty     = d.y >>> stage;
        bit_w  = (SQ_W'(1) << (SQ_W - 2)) >> (2 * int'(stage));
        trial  = d.root + bit_w;
        // one cordic vectoring step
        if (int'(stage) < CORDIC_STAGES)
        begin
            if (!d.y[CW-1])
            begin
                q_next.x = d.x + ty;
                q_next.y = d.y - tx;
                q_next.z = d.z + atan_turn(stage);
            end
            else
            begin
                q_next.x = d.x - ty;
                q_next.y = d.y + tx;
                q_next.z = d.z - atan_turn(stage);
            end
        end
        // one bit of the magnitude root
        if (int'(stage) < SQRT_STEPS)
        begin
            if (d.rem >= trial)
            begin
                q_next.rem  = d.rem - trial;
                q_next.root = (d.root >> 1) + bit_w;
            end
            else
            begin
                q_next.root = d.root >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// File: test/swerve_inverse_kinematics_tb.sv
module swerve_inverse_kinematics_tb;
    import sik_pkg::*;

    localparam int NSTAGE = CORDIC_STAGES;
    localparam int ABITS  = AXIS_BITS;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [15:0] axis_vertical;
    logic signed [15:0] axis_horizontal;
    logic signed [15:0] axis_spin;
    logic [3:0] swivels_ready;
    logic out_valid;
    logic out_stall;
    logic signed [15:0] front_left_angle;
    logic signed [15:0] front_right_angle;
    logic signed [15:0] back_left_angle;
    logic signed [15:0] back_right_angle;
    logic signed [18:0] front_left_speed;
    logic signed [18:0] front_right_speed;
    logic signed [18:0] back_left_speed;
    logic signed [18:0] back_right_speed;
    logic [1:0] drive_mode;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;

    typedef struct packed {
        logic [15:0] fl_ang;
        logic [15:0] fr_ang;
        logic [15:0] bl_ang;
        logic [15:0] br_ang;
        logic [18:0] fl_spd;
        logic [18:0] fr_spd;
        logic [18:0] bl_spd;
        logic [18:0] br_spd;
        logic [1:0]  mode;
    } wheel_cmd_t;

    wheel_cmd_t cmd_queue[$];
    int errors;
    int burst_left;
    int stall_mode;

    logic [15:0] geo_length;
    logic [15:0] geo_width;
    logic [15:0] gain;
    logic        wait_en;

    swerve_inverse_kinematics u_top (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint floor_shift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] atan_step(int i);
        logic [31:0] t[24];
        t = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
              10679838, 5340245, 2670163, 1335087, 667544, 333772,
              166886, 83443, 41721, 20860, 10430, 5215,
              2607, 1303, 651, 325, 162, 81};
        return t[i];
    endfunction

    function automatic logic [15:0] steer_angle(longint p, longint q);
        longint x;
        longint y;
        longint tx;
        longint ty;
        logic [31:0] z;
        logic [31:0] r;
        z = 0;
        if (p == 0 && q == 0)
            return 16'd0;
        x = q * 65536;
        y = p * 65536;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < NSTAGE && i < 24; i++)
        begin
            tx = floor_shift(x, i);
            ty = floor_shift(y, i);
            if (y >= 0)
            begin
                x += ty; y -= tx; z += atan_step(i);
            end
            else
            begin
                x -= ty; y += tx; z -= atan_step(i);
            end
        end
        r = (z + 32'h8000) >> 16;
        return 16'(17'h10000 - r[15:0]);
    endfunction

    function automatic longint wheel_rate(longint p, longint q);
        longint unsigned m;
        longint unsigned s;
        m = int_sqrt(p * p + q * q);
        s = (m * gain) >> (ABITS - 1);
        if (s > 262143)
            s = 262143;
        return s;
    endfunction

    function automatic wheel_cmd_t solve_wheels(logic signed [15:0] v, logic signed [15:0] h,
                                                logic signed [15:0] s, logic [3:0] rdy);
        wheel_cmd_t e;
        longint unsigned l2;
        longint unsigned w2;
        longint kl;
        longint kw;
        longint sl;
        longint sw;
        longint a;
        longint b;
        longint c;
        longint d;
        e = '0;
        if (v == 0 && h == 0 && s == 0)
        begin
            e.mode = MODE_IDLE;
            return e;
        end
        l2 = longint'(geo_length) * geo_length;
        w2 = longint'(geo_width) * geo_width;
        kl = 0;
        kw = 0;
        if (l2 + w2 != 0)
        begin
            kl = int_sqrt((l2 << 30) / (l2 + w2));
            kw = int_sqrt((w2 << 30) / (l2 + w2));
        end
        sl = floor_shift(longint'(s) * kl, 15);
        sw = floor_shift(longint'(s) * kw, 15);
        a = h - sl;
        b = h + sl;
        c = v - sw;
        d = v + sw;
        e.fl_ang = steer_angle(b, c);
        e.fr_ang = steer_angle(b, d);
        e.bl_ang = steer_angle(a, c);
        e.br_ang = steer_angle(a, d);
        if (wait_en && rdy != 4'hF)
        begin
            e.mode = MODE_WAIT;
            return e;
        end
        e.fl_spd = 19'(wheel_rate(b, c));
        e.fr_spd = 19'(-wheel_rate(b, d));
        e.bl_spd = 19'(wheel_rate(a, c));
        e.br_spd = 19'(-wheel_rate(a, d));
        e.mode = MODE_DRIVE;
        return e;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    // burst/gap pacing, then one request held until accepted
    task automatic send_cmd(logic signed [15:0] v, logic signed [15:0] h,
                            logic signed [15:0] s, logic [3:0] rdy);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        axis_vertical <= v;
        axis_horizontal <= h;
        axis_spin <= s;
        swivels_ready <= rdy;
        do
            @(posedge clk);
        while (in_stall);
        cmd_queue = {cmd_queue, solve_wheels(v, h, s, rdy)};
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (cmd_queue.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_LENGTH: geo_length = val;
            REG_WIDTH:  geo_width = val;
            REG_GAIN:   gain = val;
            default:    wait_en = val[0];
        endcase
    endtask

    task automatic set_config(logic [15:0] l, logic [15:0] w, logic [15:0] g, logic we);
        drain();
        write_reg(REG_LENGTH, l);
        write_reg(REG_WIDTH, w);
        write_reg(REG_GAIN, g);
        write_reg(REG_WAIT, {15'd0, we});
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_axis();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'(int'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        send_cmd(0, 0, 0, 4'hF);
        send_cmd(0, 0, 0, 4'h0);
        send_cmd(16'sh7fff, 0, 0, 4'hF);
        send_cmd(16'sh8000, 0, 0, 4'hF);
        send_cmd(0, 16'sh7fff, 0, 4'hF);
        send_cmd(0, 16'sh8000, 0, 4'hF);
        send_cmd(0, 0, 16'sh7fff, 4'hF);
        send_cmd(0, 0, 16'sh8000, 4'hF);
        send_cmd(16'sh8000, 16'sh8000, 16'sh8000, 4'hF);
        send_cmd(16'sh7fff, 16'sh7fff, 16'sh7fff, 4'hF);
        send_cmd(16'sh7fff, 16'sh8000, 16'sh7fff, 4'hF);
        send_cmd(100, -100, 50, 4'h7);
        send_cmd(100, -100, 50, 4'hE);
        send_cmd(-1, 1, 0, 4'h0);
        send_cmd(1, 0, 1, 4'hF);
        // spin too small to shift any pair: zero-pair angle
        send_cmd(0, 0, 1, 4'hF);
    endtask

    task automatic test_geometry();
        set_config(16'd65535, 16'd65535, 16'd65535, 1'b0);
        test_directed();
        set_config(16'd1, 16'd65535, 16'd0, 1'b0);
        test_directed();
        set_config(16'd65535, 16'd1, 16'd512, 1'b1);
        test_directed();
        set_config(16'd0, 16'd0, 16'd256, 1'b0);
        test_directed();
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
            send_cmd(rand_axis(), rand_axis(), rand_axis(),
                     ($urandom_range(0, 1) != 0) ? 4'hF : 4'($urandom));
    endtask

    task automatic test_random_configs();
        for (int k = 0; k < 6; k++)
        begin
            set_config(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                       16'($urandom), 1'($urandom));
            test_random(230);
            if (k == 2)
            begin
                // hold off until the pipe is empty
                in_valid <= 1'b0;
                while (cmd_queue.size() != 0)
                    @(posedge clk);
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
        set_config(16'd256, 16'd256, 16'd256, 1'b1);
        test_random(150);
    endtask

    always @(posedge clk)
    begin
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 1) == 0);
        endcase
        if ($urandom_range(0, 99) == 0)
            stall_mode <= $urandom_range(0, 2);
    end

    always @(posedge clk)
    begin
        wheel_cmd_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (cmd_queue.size() == 0)
            begin
                $display("unexpected result");
                errors++;
            end
            else
            begin
                e = cmd_queue.pop_front();
                if (front_left_angle !== e.fl_ang)
                    report("front_left_angle", front_left_angle, e.fl_ang);
                if (front_right_angle !== e.fr_ang)
                    report("front_right_angle", front_right_angle, e.fr_ang);
                if (back_left_angle !== e.bl_ang)
                    report("back_left_angle", back_left_angle, e.bl_ang);
                if (back_right_angle !== e.br_ang)
                    report("back_right_angle", back_right_angle, e.br_ang);
                if (front_left_speed !== e.fl_spd)
                    report("front_left_speed", front_left_speed, e.fl_spd);
                if (front_right_speed !== e.fr_spd)
                    report("front_right_speed", front_right_speed, e.fr_spd);
                if (back_left_speed !== e.bl_spd)
                    report("back_left_speed", back_left_speed, e.bl_spd);
                if (back_right_speed !== e.br_spd)
                    report("back_right_speed", back_right_speed, e.br_spd);
                if (drive_mode !== e.mode)
                    report("drive_mode", drive_mode, e.mode);
            end
        end
    end

    initial
    begin
        #2000000;
        $display("swerve_inverse_kinematics verification failed");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        axis_vertical = '0;
        axis_horizontal = '0;
        axis_spin = '0;
        swivels_ready = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        burst_left = 0;
        stall_mode = 1;
        geo_length = 16'd256;
        geo_width = 16'd256;
        gain = 16'd256;
        wait_en = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_geometry();
        test_random_configs();
        drain();
        if (errors == 0 && cmd_queue.size() == 0)
            $display("swerve_inverse_kinematics verification clean");
        else
            $display("swerve_inverse_kinematics verification failed");
        $finish;
    end
endmodule
